### hw/rtl/byte_string_noise_hash_core_assert.svh
// Assertion macros used by the byte string noise hash checker.
`ifndef BYTE_STRING_NOISE_HASH_CORE_ASSERT_SVH
`define BYTE_STRING_NOISE_HASH_CORE_ASSERT_SVH

// Overlapping implication, checked on every rising clock edge outside reset.
`define BSNH_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BSNH_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bsnh_pkg.sv
// Constants, types and mixing functions of the byte string noise hash.
`timescale 1ns / 1ps
package bsnh_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BYTE_W = 8;

  localparam logic [WORD_W-1:0] NOISE_K1 = 32'hd2a80a3f;
  localparam logic [WORD_W-1:0] NOISE_K2 = 32'ha884f197;
  localparam logic [WORD_W-1:0] NOISE_K3 = 32'h6c736f4b;
  localparam logic [WORD_W-1:0] NOISE_K4 = 32'hb79f3abb;
  localparam logic [WORD_W-1:0] NOISE_K5 = 32'h1b56c4f5;

  // Operand selections of the shared multiplier.
  localparam logic [2:0] OP_ACC_K1  = 3'd0;
  localparam logic [2:0] OP_B_K1    = 3'd1;
  localparam logic [2:0] OP_MIXB_K3 = 3'd2;
  localparam logic [2:0] OP_MIXA_K3 = 3'd3;
  localparam logic [2:0] OP_MID_K5  = 3'd4;
  localparam logic [2:0] OP_ACC_N1  = 3'd5;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic       take;
    logic       mul_en;
    logic [2:0] opsel;
    logic       acc_load_p;
    logic       finish;
    logic       mix;
    logic       emit;
  } bsnh_ctrl_t;

  // Seed add and the first two xor-shift rounds of the noise function.
  function automatic word_t mix_head(input word_t p, input word_t seed);
    word_t t;
    t = p + seed;
    t = t ^ (t >> 9);
    t = t + NOISE_K2;
    t = t ^ (t >> 11);
    return t;
  endfunction

  function automatic word_t mix_mid(input word_t p);
    word_t t;
    t = p ^ (p >> 13);
    t = t + NOISE_K4;
    t = t ^ (t >> 15);
    return t;
  endfunction

  function automatic word_t mix_tail(input word_t p);
    return p ^ (p >> 17);
  endfunction

endpackage

### hw/rtl/bsnh_chan_if.sv
// Valid/ready channel interfaces for input bytes and output hashes.
`timescale 1ns / 1ps
interface bsnh_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output data_byte, output has_byte, output last,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input last,
                output ready);
  modport mon (input valid, input ready, input data_byte, input has_byte,
               input last);
endinterface

interface bsnh_hash_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash;

  modport source (output valid, output hash, input ready);
  modport sink (input valid, input hash, output ready);
  modport mon (input valid, input ready, input hash);
endinterface

### hw/rtl/bsnh_mul.sv
// Shared 32 by 32 multiplier keeping the low product word in a register.
`timescale 1ns / 1ps
module bsnh_mul
  import bsnh_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  word_t a,
  input  word_t b,
  output word_t p
);

  word_t prod;

  // Only the low word is ever needed, so the product is kept at word width.
  assign prod = a * b;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= prod;
    end
  end

endmodule

### hw/rtl/bsnh_seq.sv
// Sequencer that steps the shared multiplier through the two noise evaluations.
`timescale 1ns / 1ps
module bsnh_seq
  import bsnh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_has,
  input  logic       in_last,
  input  logic       slot_free,
  output logic       in_ready,
  output bsnh_ctrl_t ctrl
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1   = 4'd1;
  localparam logic [3:0] S_M2   = 4'd2;
  localparam logic [3:0] S_M3   = 4'd3;
  localparam logic [3:0] S_M4   = 4'd4;
  localparam logic [3:0] S_M5   = 4'd5;
  localparam logic [3:0] S_M6   = 4'd6;
  localparam logic [3:0] S_M7   = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       has_r;
  logic       last_r;

  always_comb begin
    ctrl       = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.take  = 1'b1;
          state_next = in_has ? S_M1 : S_FIN;
        end
      end
      S_M1: begin
        ctrl.mul_en = 1'b1;
        ctrl.opsel  = OP_ACC_K1;
        state_next  = S_M2;
      end
      S_M2: begin
        ctrl.mul_en = 1'b1;
        ctrl.opsel  = OP_MIXB_K3;
        state_next  = S_M3;
      end
      S_M3: begin
        ctrl.mul_en = 1'b1;
        ctrl.opsel  = OP_MID_K5;
        state_next  = S_M4;
      end
      S_M4: begin
        ctrl.mul_en = 1'b1;
        ctrl.opsel  = OP_ACC_N1;
        state_next  = S_M5;
      end
      S_M5: begin
        // The product now holds the scaled accumulator; it becomes the seed.
        ctrl.mul_en     = 1'b1;
        ctrl.opsel      = OP_B_K1;
        ctrl.acc_load_p = 1'b1;
        state_next      = S_M6;
      end
      S_M6: begin
        ctrl.mul_en = 1'b1;
        ctrl.opsel  = OP_MIXA_K3;
        state_next  = S_M7;
      end
      S_M7: begin
        ctrl.mul_en = 1'b1;
        ctrl.opsel  = OP_MID_K5;
        state_next  = S_FIN;
      end
      S_FIN: begin
        ctrl.mix = has_r;
        if (!last_r) begin
          ctrl.finish = 1'b1;
          state_next  = S_IDLE;
        end else if (slot_free) begin
          ctrl.finish = 1'b1;
          ctrl.emit   = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      has_r  <= in_has;
      last_r <= in_last;
    end
  end

endmodule

### hw/rtl/byte_string_noise_hash_core.sv
// Top level of the byte string noise hash: accumulator, operand selection and output.
//
//   channel    dir   handshake      payload
//   byte_in    in    valid/ready    data_byte[7:0], has_byte, last
//   hash_out   out   valid/ready    hash[31:0]
//   cfg        in    cfg_we         cfg_wdata (char_signed)
//
// A request with a byte makes seven passes through the single shared multiplier and
// then takes the finishing state before the next ready; a request without a byte goes
// straight to the finishing state.
// Reset clears the accumulator, sets char_signed and empties the output register.
// The output register holds one hash; a last request stalls in its finishing cycle
// while an earlier hash has not been taken.
`timescale 1ns / 1ps
module byte_string_noise_hash_core
  import bsnh_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  bsnh_byte_if.sink     byte_in,
  bsnh_hash_if.source   hash_out
);

  bsnh_ctrl_t ctrl;
  logic       char_signed;
  word_t      acc;
  word_t      byte_w;
  word_t      widened;
  word_t      op_a;
  word_t      op_b;
  word_t      p;
  word_t      acc_fin;
  word_t      hash_r;
  logic       out_valid;
  logic       slot_free;

  assign slot_free = !out_valid || hash_out.ready;

  bsnh_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (byte_in.valid),
    .in_has    (byte_in.has_byte),
    .in_last   (byte_in.last),
    .slot_free (slot_free),
    .in_ready  (byte_in.ready),
    .ctrl      (ctrl)
  );

  bsnh_mul u_mul (
    .clk (clk),
    .en  (ctrl.mul_en),
    .a   (op_a),
    .b   (op_b),
    .p   (p)
  );

  assign widened = char_signed ? {{(WORD_W-BYTE_W){byte_in.data_byte[BYTE_W-1]}},
                                  byte_in.data_byte}
                               : {{(WORD_W-BYTE_W){1'b0}}, byte_in.data_byte};

  always_comb begin
    case (ctrl.opsel)
      OP_ACC_K1: begin
        op_a = acc;
        op_b = NOISE_K1;
      end
      OP_B_K1: begin
        op_a = byte_w;
        op_b = NOISE_K1;
      end
      OP_MIXB_K3: begin
        op_a = mix_head(p, byte_w);
        op_b = NOISE_K3;
      end
      OP_MIXA_K3: begin
        op_a = mix_head(p, acc);
        op_b = NOISE_K3;
      end
      OP_MID_K5: begin
        op_a = mix_mid(p);
        op_b = NOISE_K5;
      end
      OP_ACC_N1: begin
        op_a = acc;
        op_b = mix_tail(p);
      end
      default: begin
        op_a = acc;
        op_b = NOISE_K1;
      end
    endcase
  end

  assign acc_fin = ctrl.mix ? (acc ^ mix_tail(p)) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_signed <= 1'b1;
    end else if (cfg_we) begin
      char_signed <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctrl.acc_load_p) begin
      acc <= p;
    end else if (ctrl.finish) begin
      acc <= ctrl.emit ? '0 : acc_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      byte_w <= widened;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (hash_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      hash_r <= acc_fin;
    end
  end

  assign hash_out.valid = out_valid;
  assign hash_out.hash  = hash_r;

endmodule

### hw/rtl/bsnh_chk.sv
// Port-level checker for the byte string noise hash, bound to the top level.
`timescale 1ns / 1ps
`include "byte_string_noise_hash_core_assert.svh"
module bsnh_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_has,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_hash
);

  logic in_acc;
  logic byte_acc;
  logic skip_acc;
  logic out_stall;

  assign in_acc    = in_valid && in_ready;
  assign byte_acc  = in_acc && in_has;
  assign skip_acc  = in_acc && !in_has && !in_last;
  assign out_stall = out_valid && !out_ready;

  `BSNH_ASSERT_NXT(a_hold, clk, rst, out_stall, out_valid && $stable(out_hash), "hash moved")
  `BSNH_ASSERT_NXT(a_busy, clk, rst, in_acc, !in_ready, "ready right after a request")
  `BSNH_ASSERT_IMP(a_byte_busy, clk, rst, byte_acc, ##8 !in_ready, "byte request ended early")
  `BSNH_ASSERT_IMP(a_skip_done, clk, rst, skip_acc, ##2 in_ready, "empty request not done")

endmodule

bind byte_string_noise_hash_core bsnh_chk u_bsnh_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (byte_in.valid),
  .in_ready  (byte_in.ready),
  .in_has    (byte_in.has_byte),
  .in_last   (byte_in.last),
  .out_valid (hash_out.valid),
  .out_ready (hash_out.ready),
  .out_hash  (hash_out.hash)
);

### tb/testbench.sv
// Self-checking testbench for the byte string noise hash core.
`timescale 1ns / 1ps
module testbench
  import bsnh_pkg::*;
();

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  localparam logic [7:0] CORNER_BYTES [4] = '{8'h00, 8'hff, 8'h80, 8'h7f};
  localparam int         SETTLE_CYCLES    = 16;
  localparam int         PHASE_REQUESTS   = 200;

  class string_hash_scoreboard;
    word_t accumulator;
    bit    char_signed;
    word_t expected_hashes[$];
    int    errors;

    function new();
      accumulator = '0;
      char_signed = 1'b1;
      errors      = 0;
    endfunction

    function word_t squirrel(word_t position, word_t seed);
      word_t m;
      m = position * NOISE_K1;
      m = m + seed;
      m = m ^ (m >> 9);
      m = m + NOISE_K2;
      m = m ^ (m >> 11);
      m = m * NOISE_K3;
      m = m ^ (m >> 13);
      m = m + NOISE_K4;
      m = m ^ (m >> 15);
      m = m * NOISE_K5;
      m = m ^ (m >> 17);
      return m;
    endfunction

    function void note_request(logic [7:0] data_byte, logic has_byte, logic last);
      word_t wide;
      if (has_byte) begin
        wide = (char_signed && data_byte[7]) ? {24'hffffff, data_byte} : {24'h0, data_byte};
        accumulator = accumulator * squirrel(accumulator, wide);
        accumulator = accumulator ^ squirrel(wide, accumulator);
      end
      if (last) begin
        expected_hashes.push_back(accumulator);
        accumulator = '0;
      end
    endfunction

    function void check_hash(word_t actual);
      word_t expected_hash;
      if (expected_hashes.size() == 0) begin
        $display("%0t: unexpected hash, expected none, actual %h", $time, actual);
        errors++;
        return;
      end
      expected_hash = expected_hashes.pop_front();
      if (actual !== expected_hash) begin
        $display("%0t: hash mismatch, expected %h, actual %h", $time, expected_hash, actual);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  bsnh_byte_if byte_in ();
  bsnh_hash_if hash_out ();

  string_hash_scoreboard sb;

  rx_mode_e    rx_mode    = RX_ALWAYS;
  logic [15:0] rx_pattern = 16'hffff;
  logic [3:0]  rx_step    = '0;
  bit          tx_gaps;
  int          burst_left;
  int          items_sent;

  byte_string_noise_hash_core DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .byte_in  (byte_in),
    .hash_out (hash_out)
  );

  always #5 clk = ~clk;

  // The receiver checks each accepted hash and then decides its next stall.
  always @(posedge clk) begin
    if (!rst && hash_out.valid && hash_out.ready) begin
      sb.check_hash(hash_out.hash);
    end
    case (rx_mode)
      RX_ALWAYS: hash_out.ready <= 1'b1;
      RX_RANDOM: hash_out.ready <= ($urandom_range(0, 3) != 0);
      default: begin
        hash_out.ready <= rx_pattern[rx_step];
        rx_step = rx_step + 4'd1;
      end
    endcase
  end

  task automatic send_request(input logic [7:0] data_byte, input logic has_byte,
                              input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = tx_gaps ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        byte_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    byte_in.valid     <= 1'b1;
    byte_in.data_byte <= data_byte;
    byte_in.has_byte  <= has_byte;
    byte_in.last      <= last;
    do @(posedge clk); while (!byte_in.ready);
    sb.note_request(data_byte, has_byte, last);
    if (has_byte || last) items_sent++;
  endtask

  // Holds requests back until every hash has come out and the core has settled.
  task automatic drain();
    byte_in.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_char_signed(input logic value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.char_signed = value;
    cfg_we <= 1'b0;
  endtask

  task automatic directed_strings();
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hff, 1'b0, 1'b1);
    send_request(8'ha5, 1'b0, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h80, 1'b1, 1'b0);
    send_request(8'h7f, 1'b1, 1'b0);
    send_request(8'h5a, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'h01, 1'b1, 1'b1);
    send_request(8'h80, 1'b1, 1'b1);
  endtask

  // Mostly well-formed strings of random length; now and then a request with random fields.
  task automatic send_string();
    int         len;
    bit         ends_with_byte;
    logic [7:0] data_byte;
    if ($urandom_range(0, 14) == 0) begin
      send_request(8'($urandom()), 1'($urandom()), 1'($urandom()));
      return;
    end
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
    ends_with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_request(8'($urandom()), 1'b0, 1'b0);
      data_byte = ($urandom_range(0, 4) == 0) ? CORNER_BYTES[$urandom_range(0, 3)]
                                                : 8'($urandom_range(0, 255));
      send_request(data_byte, 1'b1, ends_with_byte && (i == len - 1));
    end
    if (!ends_with_byte) send_request(8'($urandom()), 1'b0, 1'b1);
  endtask

  initial begin
    int phase_end;
    int pause_at;
    bit paused;
    sb = new();
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 1'b0;
    byte_in.valid     <= 1'b0;
    byte_in.data_byte <= '0;
    byte_in.has_byte  <= 1'b0;
    byte_in.last      <= 1'b0;
    burst_left = 0;
    tx_gaps    = 1'b0;
    items_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // The first strings run with the register at its reset value.
    directed_strings();
    drain();
    write_char_signed(1'b0);
    directed_strings();

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      write_char_signed(phase == 0 ? 1'b1 : phase == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
      tx_gaps    = (phase != 0);
      rx_mode    = (phase == 0) ? RX_ALWAYS : rx_mode_e'($urandom_range(0, 2));
      rx_pattern = ($urandom_range(0, 3) == 0) ? 16'h0001 : (16'($urandom()) | 16'h0001);
      phase_end  = items_sent + PHASE_REQUESTS;
      pause_at   = items_sent + $urandom_range(40, 160);
      paused     = 1'b0;
      while (items_sent < phase_end) begin
        send_string();
        if (!paused && items_sent >= pause_at) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    if (sb.errors == 0 && sb.expected_hashes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### byte_string_noise_hash_core.f
+incdir+hw/rtl
hw/rtl/bsnh_pkg.sv
hw/rtl/bsnh_chan_if.sv
hw/rtl/bsnh_mul.sv
hw/rtl/bsnh_seq.sv
hw/rtl/byte_string_noise_hash_core.sv
hw/rtl/bsnh_chk.sv
tb/testbench.sv
